[rtl/core/background_subtract_motion_mask_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the background subtraction motion mask core.
// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BACKGROUND_SUBTRACT_MOTION_MASK_CORE_ASSERT_SVH
`define BACKGROUND_SUBTRACT_MOTION_MASK_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constants, codes and types of the background subtraction motion mask.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  localparam int unsigned MaxPixels = 131072;
  localparam int unsigned AddrW     = $clog2(MaxPixels);
  localparam int unsigned FrameW    = AddrW + 1;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned LumaW    = 11;
  localparam int unsigned ThW      = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 18;

  localparam logic [MaskW-1:0] MaskOn  = 8'hFF;
  localparam logic [MaskW-1:0] MaskOff = 8'h00;

  localparam logic [ModeW-1:0] ModeCapture   = 3'd0;
  localparam logic [ModeW-1:0] ModeSubtract  = 3'd1;
  localparam logic [ModeW-1:0] ModeSubUpdate = 3'd2;
  localparam logic [ModeW-1:0] ModeOver      = 3'd3;
  localparam logic [ModeW-1:0] ModeUnder     = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMode        = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFramePixels = 2'd2;

  localparam logic [ThW-1:0]    ThresholdReset = 8'd0;
  localparam logic [ModeW-1:0]  ModeReset      = ModeSubtract;
  localparam logic [FrameW-1:0] FrameReset     = FrameW'(76800);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SUBTRACT,
    OP_SUB_UPDATE,
    OP_OVER,
    OP_UNDER
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [LumaW-1:0] luma;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/bsm_ram.sv]
// ----------------------------------------------------------------------------
// bsm_ram
// Generic one-write, one-read RAM with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/bsm_front.sv]
// ----------------------------------------------------------------------------
// bsm_front
// Accepts pixels, forms the fake luma, tracks the pixel position and
// classifies each pixel into an operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bsm_pkg::ModeW-1:0]     mode_i,
  input  wire logic [bsm_pkg::FrameW-1:0]    frame_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bsm_pkg::ChanW-1:0]     red_i,
  input  wire logic [bsm_pkg::ChanW-1:0]     green_i,
  input  wire logic [bsm_pkg::ChanW-1:0]     blue_i,
  input  wire logic                          start_of_frame_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output bsm_pkg::entry_t                    entry_o
);
  import bsm_pkg::*;

  logic [AddrW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0]  addr;
  logic [FrameW-1:0] addr_inc;
  logic [LumaW-1:0]  luma;
  op_e               op;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign luma = LumaW'({red_i, 1'b0}) + LumaW'({green_i, 2'b00}) + LumaW'(blue_i);

  always_comb begin
    addr = start_of_frame_i ? '0 : pos_q;
    if ({1'b0, addr} >= frame_i) begin
      addr = '0;
    end
    addr_inc = {1'b0, addr} + FrameW'(1);
    pos_d    = (addr_inc >= frame_i) ? '0 : addr_inc[AddrW-1:0];
  end

  always_comb begin
    case (mode_i)
      ModeCapture:   op = OP_CAPTURE;
      ModeSubtract:  op = OP_SUBTRACT;
      ModeSubUpdate: op = OP_SUB_UPDATE;
      ModeOver:      op = OP_OVER;
      ModeUnder:     op = OP_UNDER;
      default:       op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  assign push_o  = accept;
  assign entry_o = '{op: op, addr: addr, luma: luma};

endmodule

`default_nettype wire

[rtl/core/bsm_queue.sv]
// ----------------------------------------------------------------------------
// bsm_queue
// Short FIFO of classified pixels between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bsm_pkg::entry_t push_entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output bsm_pkg::entry_t      head_o
);
  import bsm_pkg::*;

  entry_t               slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q, count_d;

  function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
    ptr_next = (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsm_back.sv]
// ----------------------------------------------------------------------------
// bsm_back
// Carries out queued operations: reads and writes the background store,
// compares against the threshold and holds the result for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [bsm_pkg::LumaW-1:0]  th7_i,
  input  wire logic                       q_valid_i,
  input  wire bsm_pkg::entry_t            q_head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [bsm_pkg::MaskW-1:0]  mask_o,
  output logic      [bsm_pkg::LumaW-1:0]  fake_luma_o
);
  import bsm_pkg::*;

  logic             pop, emit, store_we, need_read;
  logic             s2_valid_q, s2_valid_d, s2_adv;
  op_e              s2_op_q;
  logic [LumaW-1:0] s2_luma_q;
  logic [LumaW-1:0] bg, diff;
  logic             flagged;
  logic             out_valid_q;
  logic [MaskW-1:0] out_mask_q;
  logic [LumaW-1:0] out_luma_q;

  assign emit = (q_head_i.op == OP_SUBTRACT) || (q_head_i.op == OP_SUB_UPDATE) ||
                (q_head_i.op == OP_OVER) || (q_head_i.op == OP_UNDER);
  assign need_read = (q_head_i.op == OP_SUBTRACT) || (q_head_i.op == OP_SUB_UPDATE);

  assign s2_adv   = s2_valid_q && (!out_valid_q || out_ready_i);
  assign pop      = q_valid_i && (!s2_valid_q || s2_adv);
  assign store_we = pop && ((q_head_i.op == OP_CAPTURE) || (q_head_i.op == OP_SUB_UPDATE));
  assign pop_o    = pop;

  bsm_ram #(
    .Width (LumaW),
    .Depth (MaxPixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (q_head_i.addr),
    .wdata_i (q_head_i.luma),
    .re_i    (pop && need_read),
    .raddr_i (q_head_i.addr),
    .rdata_o (bg)
  );

  assign diff = (s2_luma_q >= bg) ? (s2_luma_q - bg) : (bg - s2_luma_q);

  always_comb begin
    case (s2_op_q)
      OP_SUBTRACT,
      OP_SUB_UPDATE: flagged = (diff > th7_i);
      OP_OVER:       flagged = (s2_luma_q > th7_i);
      OP_UNDER:      flagged = (s2_luma_q < th7_i);
      default:       flagged = 1'b0;
    endcase
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pop) begin
      s2_valid_d = emit;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_op_q   <= q_head_i.op;
      s2_luma_q <= q_head_i.luma;
    end
    if (s2_adv) begin
      out_mask_q <= flagged ? MaskOn : MaskOff;
      out_luma_q <= s2_luma_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mask_o      = out_mask_q;
  assign fake_luma_o = out_luma_q;

endmodule

`default_nettype wire

[rtl/core/background_subtract_motion_mask_core.sv]
// ----------------------------------------------------------------------------
// background_subtract_motion_mask_core
// Per-pixel motion mask from fake luma against a stored background frame.
// ----------------------------------------------------------------------------
// The core takes one RGB pixel per clock and sustains one pixel per clock in
// every mode while the output is not stalled, set by the single read and write
// ports of the background store, each used at most once per pixel. A result
// passes the queue, stage two and the output register; capture mode and unused
// mode codes give no result. The store holds 131072 entries of 11 bits and has
// no reset: an entry must be captured before it is compared against. The user
// writes configuration only while the core is idle; it is not enforced.
`default_nettype none

module background_subtract_motion_mask_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bsm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bsm_pkg::ChanW-1:0]     red_i,
  input  wire logic [bsm_pkg::ChanW-1:0]     green_i,
  input  wire logic [bsm_pkg::ChanW-1:0]     blue_i,
  input  wire logic                          start_of_frame_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bsm_pkg::MaskW-1:0]     mask_o,
  output logic      [bsm_pkg::LumaW-1:0]     fake_luma_o
);
  import bsm_pkg::*;

  `include "background_subtract_motion_mask_core_assert.svh"

  logic [ThW-1:0]    threshold_q;
  logic [LumaW-1:0]  th7_q;
  logic [ModeW-1:0]  mode_q;
  logic [FrameW-1:0] frame_q, frame_d;

  logic   q_full, q_valid, push, pop;
  entry_t push_entry, head;

  always_comb begin
    if (cfg_data_i == '0) begin
      frame_d = FrameW'(1);
    end else if (cfg_data_i > CfgDataW'(MaxPixels)) begin
      frame_d = FrameW'(MaxPixels);
    end else begin
      frame_d = FrameW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      th7_q       <= '0;
      mode_q      <= ModeReset;
      frame_q     <= FrameReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgThreshold: begin
          threshold_q <= cfg_data_i[ThW-1:0];
          th7_q       <= LumaW'({cfg_data_i[ThW-1:0], 3'b000}) - LumaW'(cfg_data_i[ThW-1:0]);
        end
        CfgMode:        mode_q  <= cfg_data_i[ModeW-1:0];
        CfgFramePixels: frame_q <= frame_d;
        default: ;
      endcase
    end
  end

  bsm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .frame_i          (frame_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .start_of_frame_i (start_of_frame_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  bsm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  bsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .th7_i       (th7_q),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mask_o      (mask_o),
    .fake_luma_o (fake_luma_o)
  );

  `BSM_ASSERT_NOW(a_mask_code, out_valid_o, (mask_o == MaskOn) || (mask_o == MaskOff), "mask is neither 0 nor 255")
  `BSM_ASSERT_NOW(a_luma_range, out_valid_o, fake_luma_o <= LumaW'(1785), "fake luma out of range")
  `BSM_ASSERT_NOW(a_th7_scale, 1'b1, th7_q == (LumaW'(threshold_q) * LumaW'(7)), "scaled threshold out of step")
  `BSM_ASSERT_NEXT(a_frame_range, cfg_we_i && (cfg_index_i == CfgFramePixels), (frame_q != '0) && (frame_q <= FrameW'(MaxPixels)), "frame size out of range")

endmodule

`default_nettype wire

[tb/tb_background_subtract_motion_mask_core.sv]
// ----------------------------------------------------------------------------
// tb_background_subtract_motion_mask_core
// Self-checking bench for the background subtraction motion mask core. Pixels
// are driven from a queue with random gaps and results are taken with random
// back-pressure. A behavioral predictor keeps its own background store and
// position counter and checks mask and fake luma of every result in order.
// ----------------------------------------------------------------------------
module tb_background_subtract_motion_mask_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  localparam logic [ModeW-1:0]   ModeSpareLo  = 3'd5;
  localparam logic [ModeW-1:0]   ModeSpareMid = 3'd6;
  localparam logic [ModeW-1:0]   ModeSpareHi  = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpare     = 2'd3;
  localparam int                 SettleCycles = 8;
  localparam int                 CycleLimit   = 200000;
  localparam int                 PartItems    = 115;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             sof;
    bit               drain;
  } pixel_t;

  typedef struct {
    logic [MaskW-1:0] mask;
    logic [LumaW-1:0] fake_luma;
  } mask_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [ChanW-1:0]    red         = '0;
  logic [ChanW-1:0]    green       = '0;
  logic [ChanW-1:0]    blue        = '0;
  logic                sof         = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [MaskW-1:0]    mask;
  logic [LumaW-1:0]    fake_luma;

  pixel_t       pixel_queue[$];
  pixel_t       cur_pixel;
  mask_result_t pending_masks[$];

  logic [ThW-1:0]    thr_reg   = ThresholdReset;
  logic [ModeW-1:0]  mode_reg  = ModeReset;
  logic [FrameW-1:0] frame_reg = FrameReset;
  logic [FrameW-1:0] position  = '0;
  logic [LumaW-1:0]  background_luma [MaxPixels];

  logic [FrameW-1:0] gen_pos = '0;
  bit                gen_written [MaxPixels];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  background_subtract_motion_mask_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .start_of_frame_i (sof),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .mask_o           (mask),
    .fake_luma_o      (fake_luma)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [FrameW-1:0] frame_limit(logic [FrameW-1:0] fp);
    if (fp == '0) return FrameW'(1);
    if (fp > FrameW'(MaxPixels)) return FrameW'(MaxPixels);
    return fp;
  endfunction

  function automatic void predict_pixel(pixel_t px);
    logic [LumaW-1:0]  luma;
    logic [LumaW-1:0]  th;
    logic [LumaW-1:0]  bg;
    logic [LumaW-1:0]  diff;
    logic [FrameW-1:0] frame;
    logic [FrameW-1:0] addr;
    logic              flagged;
    bit                emit;
    luma    = (LumaW'(px.red) << 1) + (LumaW'(px.green) << 2) + LumaW'(px.blue);
    th      = LumaW'(thr_reg * 7);
    frame   = frame_limit(frame_reg);
    addr    = px.sof ? '0 : position;
    if (addr >= frame) addr = '0;
    bg      = background_luma[addr[AddrW-1:0]];
    flagged = 1'b0;
    emit    = 1'b1;
    case (mode_reg)
      ModeCapture: begin
        background_luma[addr[AddrW-1:0]] = luma;
        emit = 1'b0;
      end
      ModeSubtract, ModeSubUpdate: begin
        diff    = (luma >= bg) ? luma - bg : bg - luma;
        flagged = diff > th;
        if (mode_reg == ModeSubUpdate) background_luma[addr[AddrW-1:0]] = luma;
      end
      ModeOver:  flagged = luma > th;
      ModeUnder: flagged = luma < th;
      default:   emit = 1'b0;
    endcase
    position = (addr + 1'b1 >= frame) ? '0 : addr + 1'b1;
    if (emit) pending_masks.push_back('{mask: flagged ? MaskOn : MaskOff, fake_luma: luma});
  endfunction

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                    logic [ChanW-1:0] b, logic first, bit drain);
    logic [FrameW-1:0] frame;
    logic [FrameW-1:0] addr;
    frame = frame_limit(frame_reg);
    addr  = first ? '0 : gen_pos;
    if (addr >= frame) addr = '0;
    // A compare against a background entry that was never captured is not
    // allowed, so such a pixel is moved to the start of the frame instead.
    if ((mode_reg == ModeSubtract || mode_reg == ModeSubUpdate) &&
        !gen_written[addr[AddrW-1:0]]) begin
      first = 1'b1;
      addr  = '0;
    end
    if (mode_reg == ModeCapture || mode_reg == ModeSubUpdate) gen_written[addr[AddrW-1:0]] = 1'b1;
    gen_pos = (addr + 1'b1 >= frame) ? '0 : addr + 1'b1;
    pixel_queue.push_back('{red: r, green: g, blue: b, sof: first, drain: drain});
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CfgThreshold:   thr_reg   = data[ThW-1:0];
      CfgMode:        mode_reg  = data[ModeW-1:0];
      CfgFramePixels: frame_reg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [ThW-1:0] thr, logic [ModeW-1:0] md, logic [FrameW-1:0] fp);
    write_reg(CfgThreshold, CfgDataW'({$urandom(), thr}));
    write_reg(CfgMode, CfgDataW'({$urandom(), md}));
    write_reg(CfgFramePixels, fp);
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid || pending_masks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_phase(output int n_done);
    logic [ModeW-1:0]  md;
    logic [FrameW-1:0] fp;
    logic [ThW-1:0]    thr;
    int                sel;
    int                n;
    sel = $urandom_range(0, 19);
    if (sel < 14)       fp = FrameW'($urandom_range(1, 48));
    else if (sel < 16)  fp = FrameW'(1);
    else if (sel == 16) fp = '0;
    else if (sel == 17) fp = FrameW'(MaxPixels);
    else if (sel == 18) fp = '1;
    else                fp = FrameW'($urandom_range(49, 4000));
    sel = $urandom_range(0, 7);
    if (sel == 0)      thr = '0;
    else if (sel == 1) thr = '1;
    else               thr = ThW'($urandom_range(0, 100));
    sel = $urandom_range(0, 19);
    if (sel < 2)       md = ModeCapture;
    else if (sel < 8)  md = ModeSubtract;
    else if (sel < 13) md = ModeSubUpdate;
    else if (sel < 16) md = ModeOver;
    else if (sel < 19) md = ModeUnder;
    else               md = ModeW'($urandom_range(ModeSpareLo, ModeSpareHi));
    n_done = 0;
    if ((md == ModeSubtract || md == ModeSubUpdate) && frame_limit(fp) <= FrameW'(64) &&
        $urandom_range(0, 2) != 0) begin
      set_config(thr, ModeCapture, fp);
      for (int i = 0; i < int'(frame_limit(fp)); i++) begin
        add_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0, 1'b0);
      end
      n_done += int'(frame_limit(fp));
      wait_idle();
    end
    set_config(thr, md, fp);
    if ($urandom_range(0, 7) == 0) write_reg(CfgSpare, CfgDataW'($urandom()));
    n = $urandom_range(10, 40);
    for (int i = 0; i < n; i++) begin
      add_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 15) == 0,
                i == n / 2 && $urandom_range(0, 3) == 0);
    end
    n_done += n;
    wait_idle();
  endtask

  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    bit     take;
    if (in_valid && in_ready) predict_pixel(cur_pixel);
    if (!in_valid || in_ready) begin
      take = rst_n && pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
      if (take) begin
        if (pixel_queue[0].drain && pending_masks.size() != 0) take = 1'b0;
      end
      if (take) begin
        nxt = pixel_queue.pop_front();
        cur_pixel <= nxt;
        red       <= nxt.red;
        green     <= nxt.green;
        blue      <= nxt.blue;
        sof       <= nxt.sof;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_masks
    mask_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("unexpected result mask=%0h luma=%0d", mask, fake_luma));
      end else begin
        exp = pending_masks.pop_front();
        if (mask !== exp.mask)
          report_mismatch($sformatf("mask %0h, expected %0h", mask, exp.mask));
        if (fake_luma !== exp.fake_luma)
          report_mismatch($sformatf("fake luma %0d, expected %0d", fake_luma, exp.fake_luma));
      end
    end
    out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int done;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 29;
    recv_idle_pct = 50;
    repeat (2) @(posedge clk);

    set_config(8'd0, ModeCapture, FrameW'(4));
    add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd255, ModeSubtract, FrameW'(4));
    add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd0, ModeSubUpdate, FrameW'(4));
    add_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    wait_idle();
    set_config(8'd0, ModeOver, FrameW'(4));
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd255, ModeUnder, FrameW'(4));
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    add_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd0, ModeSpareLo, FrameW'(4));
    add_pixel(8'd17, 8'd34, 8'd51, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd0, ModeSpareHi, FrameW'(4));
    add_pixel(8'd170, 8'd85, 8'd204, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd9, ModeSubtract, '0);
    add_pixel(8'd3, 8'd5, 8'd7, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd0, ModeOver, FrameW'(4));
    add_pixel(8'd1, 8'd0, 8'd0, 1'b1, 1'b0);
    add_pixel(8'd0, 8'd1, 8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd0, 8'd2, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd100, ModeSubtract, FrameW'(2));
    add_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b0);
    wait_idle();
    set_config(8'd50, ModeOver, '1);
    write_reg(CfgSpare, '1);
    add_pixel(8'd100, 8'd50, 8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 8'd100, 8'd0, 1'b0, 1'b0);
    wait_idle();
    write_reg(CfgSpare, '0);
    set_config(8'd0, ModeSpareMid, FrameW'(4));
    wait_idle();

    for (int part = 0; part < 3; part++) begin
      send_idle_pct = (part == 0) ? 29 : (part == 1) ? 50 : 0;
      recv_idle_pct = (part == 0) ? 50 : (part == 1) ? 29 : 0;
      done = 0;
      while (done < PartItems) begin
        random_phase(n);
        done += n;
      end
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[background_subtract_motion_mask_core.f]
+incdir+rtl/core
rtl/core/bsm_pkg.sv
rtl/core/bsm_ram.sv
rtl/core/bsm_front.sv
rtl/core/bsm_queue.sv
rtl/core/bsm_back.sv
rtl/core/background_subtract_motion_mask_core.sv
tb/tb_background_subtract_motion_mask_core.sv
